// File: hdl/jtl_pkg.sv
// jtl_pkg: shared constants, token codes and the run record of the token lexer
// depends on nothing; imported by every module of the lexer

package jtl_pkg;

  localparam int NUMBER_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH      = 4;
  localparam int RUN_MAX          = 3;

  typedef logic [3:0] kind_t;
  typedef logic [7:0] byte_t;
  typedef logic [1:0] run_cnt_t;

  // token kinds
  localparam kind_t K_EOF      = 4'd0;
  localparam kind_t K_LBRACE   = 4'd1;
  localparam kind_t K_RBRACE   = 4'd2;
  localparam kind_t K_LBRACKET = 4'd3;
  localparam kind_t K_RBRACKET = 4'd4;
  localparam kind_t K_COLON    = 4'd5;
  localparam kind_t K_COMMA    = 4'd6;
  localparam kind_t K_CHAR     = 4'd7;
  localparam kind_t K_STREND   = 4'd8;
  localparam kind_t K_NUMBER   = 4'd9;
  localparam kind_t K_ERROR    = 4'd10;

  // text bytes
  localparam byte_t CH_LBRACE   = 8'h7B;
  localparam byte_t CH_RBRACE   = 8'h7D;
  localparam byte_t CH_LBRACKET = 8'h5B;
  localparam byte_t CH_RBRACKET = 8'h5D;
  localparam byte_t CH_COLON    = 8'h3A;
  localparam byte_t CH_COMMA    = 8'h2C;
  localparam byte_t CH_MINUS    = 8'h2D;
  localparam byte_t CH_ZERO     = 8'h30;
  localparam byte_t CH_NINE     = 8'h39;
  localparam byte_t CH_SLASH    = 8'h2F;
  localparam byte_t CH_STAR     = 8'h2A;
  localparam byte_t CH_QUOTE    = 8'h22;
  localparam byte_t CH_BSLASH   = 8'h5C;
  localparam byte_t CH_N        = 8'h6E;
  localparam byte_t CH_T        = 8'h74;
  localparam byte_t CH_R        = 8'h72;
  localparam byte_t CH_LF       = 8'h0A;
  localparam byte_t CH_TAB      = 8'h09;
  localparam byte_t CH_CR       = 8'h0D;

  // tokens caused by one input transaction; at most one character and one number
  typedef struct packed {
    run_cnt_t                count;
    kind_t [RUN_MAX-1:0]     kinds;
    byte_t                   ch;
    logic                    neg;
  } run_t;

  // head of the run queue as seen by the token sequencer
  typedef struct packed {
    logic valid;
    run_t run;
  } head_t;

endpackage

// File: hdl/jtl_if.sv
// jtl_if: valid/ready channel interfaces for text bytes in and tokens out
// depends on nothing

interface jtl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       byte_present;
  logic       end_of_text;

  modport source (output valid, text_byte, byte_present, end_of_text, input ready);
  modport sink   (input valid, text_byte, byte_present, end_of_text, output ready);
endinterface

interface jtl_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         token_kind;
  logic [7:0]         char_value;
  logic signed [31:0] number_value;
  logic               last_of_run;

  modport source (output valid, token_kind, char_value, number_value, last_of_run,
                  input ready);
  modport sink   (input valid, token_kind, char_value, number_value, last_of_run,
                  output ready);
endinterface

// File: hdl/jtl_front.sv
// jtl_front: lexer state machine, classifies one byte per cycle into a run of tokens
// while the queue is not full; depends on jtl_pkg

module jtl_front import jtl_pkg::*; #(
  parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  byte_t                   in_text_byte,
  input  logic                    in_byte_present,
  input  logic                    in_end_of_text,
  input  logic                    q_full,
  output logic                    push,
  output run_t                    push_run,
  output logic [NUMBER_WIDTH-1:0] push_mag
);

  localparam int AW = NUMBER_WIDTH + 4;
  localparam logic [NUMBER_WIDTH-1:0] CAP = {1'b1, {(NUMBER_WIDTH-1){1'b0}}};

  localparam logic [3:0] M_IDLE  = 4'd0;
  localparam logic [3:0] M_SLASH = 4'd1;
  localparam logic [3:0] M_LINE  = 4'd2;
  localparam logic [3:0] M_BLOCK = 4'd3;
  localparam logic [3:0] M_BSTAR = 4'd4;
  localparam logic [3:0] M_STR   = 4'd5;
  localparam logic [3:0] M_ESC   = 4'd6;
  localparam logic [3:0] M_NUM   = 4'd7;
  localparam logic [3:0] M_MINUS = 4'd8;

  logic [3:0]              mode_r, mode_nxt;
  logic [NUMBER_WIDTH-1:0] mag_r, mag_nxt;
  logic                    neg_r, neg_nxt;

  logic                    accept;
  logic                    is_dig;
  logic [NUMBER_WIDTH-1:0] base;
  logic [AW-1:0]           acc;
  logic [NUMBER_WIDTH-1:0] added;
  run_t                    run;
  logic [NUMBER_WIDTH-1:0] num_mag;
  logic                    go_idle;
  byte_t                   esc_ch;

  function automatic run_t add_tok(run_t r, kind_t k);
    run_t t;
    t = r;
    if (t.count != run_cnt_t'(RUN_MAX)) begin
      t.kinds[t.count] = k;
      t.count          = t.count + run_cnt_t'(1);
    end
    return t;
  endfunction

  assign accept   = in_valid && in_ready;
  assign in_ready = !q_full;

  // digit accumulate with clamp at the magnitude limit
  assign is_dig = (in_text_byte >= CH_ZERO) && (in_text_byte <= CH_NINE);
  assign base   = (mode_r == M_NUM) ? mag_r : '0;
  assign acc    = ({4'b0, base} << 3) + ({4'b0, base} << 1) + AW'(in_text_byte[3:0]);
  assign added  = (acc > {4'b0, CAP}) ? CAP : acc[NUMBER_WIDTH-1:0];

  always_comb begin
    case (in_text_byte)
      CH_N:    esc_ch = CH_LF;
      CH_T:    esc_ch = CH_TAB;
      CH_R:    esc_ch = CH_CR;
      default: esc_ch = in_text_byte;
    endcase
  end

  always_comb begin
    mode_nxt = mode_r;
    mag_nxt  = mag_r;
    neg_nxt  = neg_r;
    run      = '0;
    num_mag  = mag_r;
    go_idle  = 1'b0;
    if (in_byte_present) begin
      case (mode_r)
        M_SLASH: begin
          if (in_text_byte == CH_SLASH)     mode_nxt = M_LINE;
          else if (in_text_byte == CH_STAR) mode_nxt = M_BLOCK;
          else                              go_idle  = 1'b1;
        end
        M_LINE: begin
          if (in_text_byte == CH_LF) mode_nxt = M_IDLE;
        end
        M_BLOCK: begin
          if (in_text_byte == CH_STAR) mode_nxt = M_BSTAR;
        end
        M_BSTAR: begin
          if (in_text_byte == CH_SLASH)      mode_nxt = M_IDLE;
          else if (in_text_byte != CH_STAR) mode_nxt = M_BLOCK;
        end
        M_STR: begin
          if (in_text_byte == CH_QUOTE) begin
            run      = add_tok(run, K_STREND);
            mode_nxt = M_IDLE;
          end else if (in_text_byte == CH_BSLASH) begin
            mode_nxt = M_ESC;
          end else begin
            run    = add_tok(run, K_CHAR);
            run.ch = in_text_byte;
          end
        end
        M_ESC: begin
          run      = add_tok(run, K_CHAR);
          run.ch   = esc_ch;
          mode_nxt = M_STR;
        end
        M_NUM: begin
          if (is_dig) begin
            mag_nxt = added;
          end else begin
            run     = add_tok(run, K_NUMBER);
            num_mag = mag_r;
            run.neg = neg_r;
            go_idle = 1'b1;
          end
        end
        M_MINUS: begin
          if (is_dig) begin
            mode_nxt = M_NUM;
            mag_nxt  = added;
          end else begin
            run     = add_tok(run, K_ERROR);
            go_idle = 1'b1;
          end
        end
        default: go_idle = 1'b1;
      endcase
      if (go_idle) begin
        mode_nxt = M_IDLE;
        case (in_text_byte)
          CH_LBRACE:   run = add_tok(run, K_LBRACE);
          CH_RBRACE:   run = add_tok(run, K_RBRACE);
          CH_LBRACKET: run = add_tok(run, K_LBRACKET);
          CH_RBRACKET: run = add_tok(run, K_RBRACKET);
          CH_COLON:    run = add_tok(run, K_COLON);
          CH_COMMA:    run = add_tok(run, K_COMMA);
          CH_SLASH:    mode_nxt = M_SLASH;
          CH_QUOTE:    mode_nxt = M_STR;
          CH_MINUS: begin
            mode_nxt = M_MINUS;
            neg_nxt  = 1'b1;
            mag_nxt  = '0;
          end
          default: begin
            if (is_dig) begin
              mode_nxt = M_NUM;
              neg_nxt  = 1'b0;
              mag_nxt  = added;
            end
          end
        endcase
      end
    end
    if (in_end_of_text) begin
      case (mode_nxt)
        M_STR, M_ESC, M_MINUS: run = add_tok(run, K_ERROR);
        M_NUM: begin
          run     = add_tok(run, K_NUMBER);
          num_mag = mag_nxt;
          run.neg = neg_nxt;
        end
        default: ;
      endcase
      run      = add_tok(run, K_EOF);
      mode_nxt = M_IDLE;
      mag_nxt  = '0;
      neg_nxt  = 1'b0;
    end
  end

  assign push     = accept && (run.count != '0);
  assign push_run = run;
  assign push_mag = num_mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      mag_r  <= '0;
      neg_r  <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      mag_r  <= mag_nxt;
      neg_r  <= neg_nxt;
    end
  end

endmodule

// File: hdl/jtl_queue.sv
// jtl_queue: short flip-flop queue of token runs between lexer and sequencer
// depends on jtl_pkg

module jtl_queue import jtl_pkg::*; #(
  parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  run_t                    push_run,
  input  logic [NUMBER_WIDTH-1:0] push_mag,
  output logic                    full,
  input  logic                    pop,
  output head_t                   head,
  output logic [NUMBER_WIDTH-1:0] head_mag
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  run_t                    run_q [QUEUE_DEPTH];
  logic [NUMBER_WIDTH-1:0] mag_q [QUEUE_DEPTH];
  logic [PW-1:0]           wr_ptr_r, rd_ptr_r;
  logic [PW:0]             cnt_r, cnt_nxt;

  assign full       = (cnt_r == (PW+1)'(QUEUE_DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.run   = run_q[rd_ptr_r];
  assign head_mag   = mag_q[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop)      cnt_nxt = cnt_r + (PW+1)'(1);
    else if (pop && !push) cnt_nxt = cnt_r - (PW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PW'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      run_q[wr_ptr_r] <= push_run;
      mag_q[wr_ptr_r] <= push_mag;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("run pushed into a full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) pop |-> head.valid)
    else $error("run popped from an empty queue");

endmodule

// File: hdl/jtl_back.sv
// jtl_back: token sequencer, walks each queued run and drives the output register
// depends on jtl_pkg

module jtl_back import jtl_pkg::*; #(
  parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  head_t                   head,
  input  logic [NUMBER_WIDTH-1:0] head_mag,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output kind_t                   out_kind,
  output byte_t                   out_char,
  output logic signed [31:0]      out_number,
  output logic                    out_last
);

  localparam logic [NUMBER_WIDTH-1:0] CAP = {1'b1, {(NUMBER_WIDTH-1){1'b0}}};

  logic                      out_valid_r;
  run_cnt_t                  sel_r, sel_nxt;
  kind_t                     kind_r, kind_nxt;
  byte_t                     char_r, char_nxt;
  logic signed [31:0]        num_r, num_nxt;
  logic                      last_r, last_nxt;
  logic                      load;
  logic signed [NUMBER_WIDTH-1:0] val_w;
  logic signed [63:0]        val_ext;

  assign load     = head.valid && (!out_valid_r || out_ready);
  assign last_nxt = ((sel_r + run_cnt_t'(1)) == head.run.count);
  assign pop      = load && last_nxt;
  assign sel_nxt  = load ? (last_nxt ? '0 : sel_r + run_cnt_t'(1)) : sel_r;
  assign kind_nxt = head.run.kinds[sel_r];

  // signed value with clamp of the positive side
  assign val_w   = head.run.neg ? -head_mag : ((head_mag >= CAP) ? CAP - 1'b1 : head_mag);
  assign val_ext = 64'(val_w);

  assign char_nxt = (kind_nxt == K_CHAR) ? head.run.ch : '0;
  assign num_nxt  = (kind_nxt == K_NUMBER) ? val_ext[31:0] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_r       <= '0;
    end else begin
      sel_r <= sel_nxt;
      if (load)           out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= kind_nxt;
      char_r <= char_nxt;
      num_r  <= num_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = kind_r;
  assign out_char   = char_r;
  assign out_number = num_r;
  assign out_last   = last_r;

  a_sel_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    head.valid |-> (sel_r < head.run.count))
    else $error("token index beyond run length");
  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (kind_r == K_EOF)) |-> last_r)
    else $error("eof token not marked last of run");

endmodule

// File: hdl/jsonc_token_lexer_top.sv
// an accepted byte's run is written to the queue, then its tokens to the output register
// throughput: one byte per cycle in while the queue has room; one token per cycle out
//   when ready; runs go out token by token and the four-run queue absorbs the difference
// reset: synchronous active-low rst_n clears lexer mode, number accumulator, queue
//   pointers and output valid; no clearing pass
// depends on jtl_pkg, jtl_if, jtl_front, jtl_queue, jtl_back

module jsonc_token_lexer_top import jtl_pkg::*; #(
  parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input logic     clk,
  input logic     rst_n,
  jtl_in_if.sink  in_ch,
  jtl_out_if.source out_ch
);

  // front to queue: one run record per byte transaction that makes tokens
  logic                    push;
  run_t                    push_run;
  logic [NUMBER_WIDTH-1:0] push_mag;
  logic                    q_full;

  // queue to back: head run and its number magnitude
  head_t                   head;
  logic [NUMBER_WIDTH-1:0] head_mag;
  logic                    pop;

  // lexer: ready only depends on queue room, so a waiting token never blocks input
  // while the queue has space
  jtl_front #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_text_byte    (in_ch.text_byte),
    .in_byte_present (in_ch.byte_present),
    .in_end_of_text  (in_ch.end_of_text),
    .q_full          (q_full),
    .push            (push),
    .push_run        (push_run),
    .push_mag        (push_mag)
  );

  // decoupling queue between lexer and token sequencer
  jtl_queue #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_run (push_run),
    .push_mag (push_mag),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .head_mag (head_mag)
  );

  // sequencer: one token per output transaction, signs and clamps the number here
  jtl_back #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_mag   (head_mag),
    .pop        (pop),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_kind   (out_ch.token_kind),
    .out_char   (out_ch.char_value),
    .out_number (out_ch.number_value),
    .out_last   (out_ch.last_of_run)
  );

endmodule
